>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cons must hold in every cycle where ante holds
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cond must never hold
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

>>> hw/rtl/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDE_WORDS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIG_ENDIAN = 8'd1;

  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int PEND_W      = 4;
  localparam int QUEUE_DEPTH = 4;

  // Everything one byte produces: an optional closed run, an optional summary.
  typedef struct packed {
    logic        run_valid;
    logic        summary_valid;
    logic [31:0] run_start;
    logic [31:0] run_length;
    logic [31:0] total_runs;
  } event_t;

endpackage

`default_nettype wire

>>> hw/rtl/ipc_front.sv
`default_nettype none

`include "assert_macros.svh"

module ipc_front #(
  parameter int OFFSET_WIDTH   = 32,
  parameter int MAX_WORD_BYTES = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  input  wire logic [ipc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic                             cfg_data,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             final_byte,
  output logic                                  push,
  output ipc_pkg::event_t                       push_event
);

  localparam int WinDepth  = 2 * MAX_WORD_BYTES;
  localparam int WideBytes = (MAX_WORD_BYTES < 4) ? MAX_WORD_BYTES : 4;
  localparam logic [31:0] WideMask = 32'((33'h1 << (8 * WideBytes)) - 33'h1);
  localparam int ExtW = (OFFSET_WIDTH > 32) ? OFFSET_WIDTH : 32;

  logic wide_words;
  logic big_endian;

  logic [WinDepth-1:0][7:0]     win;
  logic [ipc_pkg::PEND_W-1:0]   pending;
  logic [OFFSET_WIDTH-1:0]      offset;
  logic [31:0]                  mismatches;
  logic [OFFSET_WIDTH-1:0]      run_begin;
  logic [31:0]                  run_counter;

  logic [WinDepth-1:0][7:0]     win_next;
  logic [ipc_pkg::PEND_W-1:0]   pending_next;
  logic [OFFSET_WIDTH-1:0]      offset_next;
  logic [31:0]                  mismatches_next;
  logic [OFFSET_WIDTH-1:0]      run_begin_next;
  logic [31:0]                  run_counter_next;

  logic [2:0]  wsize;
  logic [15:0] a_narrow, b_narrow;
  logic [31:0] a_wide, b_wide;
  logic        match;
  logic        accept;
  logic        cfg_we;
  logic        wide_cfg;
  logic        big_cfg;
  logic [ipc_pkg::PEND_W-1:0] restart_pending;

  function automatic logic [OFFSET_WIDTH-1:0] sat_add(
    input logic [OFFSET_WIDTH-1:0] a,
    input logic [2:0]              inc
  );
    logic [OFFSET_WIDTH:0] s;
    s = {1'b0, a} + (OFFSET_WIDTH+1)'(inc);
    return s[OFFSET_WIDTH] ? '1 : s[OFFSET_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] run_len(input logic [31:0] m, input logic [2:0] w);
    logic [34:0] p;
    p = 35'(m - 32'd1) * 35'(w);
    return (p[34:32] != 3'd0) ? '1 : p[31:0];
  endfunction

  function automatic logic [31:0] start_out(input logic [OFFSET_WIDTH-1:0] s);
    logic [ExtW-1:0] e;
    e = ExtW'(s);
    return e[31:0];
  endfunction

  assign accept = in_valid && in_ready;
  assign cfg_we = cfg_valid &&
                  (cfg_index == ipc_pkg::REG_WIDE_WORDS || cfg_index == ipc_pkg::REG_BIG_ENDIAN);
  assign wide_cfg = (cfg_index == ipc_pkg::REG_WIDE_WORDS) ? cfg_data : wide_words;
  assign big_cfg  = (cfg_index == ipc_pkg::REG_BIG_ENDIAN) ? cfg_data : big_endian;
  assign restart_pending = wide_cfg ? ipc_pkg::PEND_W'(2 * WideBytes) : ipc_pkg::PEND_W'(4);
  assign wsize = wide_words ? 3'(WideBytes) : 3'd2;

  // Assemble both candidate words for each word size from the shifted window.
  always_comb begin
    win_next = {win[WinDepth-2:0], data_byte};
    a_narrow = '0;
    b_narrow = '0;
    a_wide   = '0;
    b_wide   = '0;
    for (int k = 0; k < 2; k++) begin
      if (big_endian) begin
        a_narrow[8*k +: 8] = win_next[2 + k];
        b_narrow[8*k +: 8] = win_next[k];
      end else begin
        a_narrow[8*k +: 8] = win_next[3 - k];
        b_narrow[8*k +: 8] = win_next[1 - k];
      end
    end
    for (int k = 0; k < WideBytes; k++) begin
      if (big_endian) begin
        a_wide[8*k +: 8] = win_next[WideBytes + k];
        b_wide[8*k +: 8] = win_next[k];
      end else begin
        a_wide[8*k +: 8] = win_next[2*WideBytes - 1 - k];
        b_wide[8*k +: 8] = win_next[WideBytes - 1 - k];
      end
    end
    if (wide_words) begin
      match = ((b_wide - a_wide) & WideMask) == 32'd1;
    end else begin
      match = (b_narrow - a_narrow) == 16'd1;
    end
  end

  always_comb begin
    pending_next     = (pending != '0) ? pending - 1'b1 : pending;
    offset_next      = offset;
    mismatches_next  = mismatches;
    run_begin_next   = run_begin;
    run_counter_next = run_counter;
    push_event       = '0;

    if (pending_next == '0) begin
      if (match) begin
        if (mismatches != '0) begin
          push_event.run_valid  = 1'b1;
          push_event.run_start  = start_out(run_begin);
          push_event.run_length = run_len(mismatches, wsize);
        end
        mismatches_next = '0;
        offset_next     = sat_add(offset, wsize);
        pending_next    = ipc_pkg::PEND_W'(wsize);
      end else begin
        if (mismatches == '0) begin
          run_begin_next   = sat_add(offset, wsize);
          run_counter_next = (run_counter != '1) ? run_counter + 32'd1 : run_counter;
          mismatches_next  = 32'd1;
        end else if (mismatches != '1) begin
          mismatches_next = mismatches + 32'd1;
        end
        offset_next  = sat_add(offset, 3'd1);
        pending_next = ipc_pkg::PEND_W'(1);
      end
    end

    // Close an open run at the last byte, then summarize.
    if (final_byte) begin
      if (mismatches_next != '0) begin
        push_event.run_valid  = 1'b1;
        push_event.run_start  = start_out(run_begin_next);
        push_event.run_length = run_len(mismatches_next, wsize);
      end
      push_event.summary_valid = 1'b1;
    end
    push_event.total_runs = run_counter_next;
  end

  assign push = accept && (push_event.run_valid || push_event.summary_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_words  <= 1'b0;
      big_endian  <= 1'b0;
      win         <= '0;
      pending     <= ipc_pkg::PEND_W'(4);
      offset      <= '0;
      mismatches  <= '0;
      run_begin   <= '0;
      run_counter <= '0;
    end else if (cfg_we) begin
      wide_words  <= wide_cfg;
      big_endian  <= big_cfg;
      win         <= '0;
      pending     <= restart_pending;
      offset      <= '0;
      mismatches  <= '0;
      run_begin   <= '0;
      run_counter <= '0;
    end else if (accept) begin
      if (final_byte) begin
        win         <= '0;
        pending     <= ipc_pkg::PEND_W'(2) * ipc_pkg::PEND_W'(wsize);
        offset      <= '0;
        mismatches  <= '0;
        run_begin   <= '0;
        run_counter <= '0;
      end else begin
        win         <= win_next;
        pending     <= pending_next;
        offset      <= offset_next;
        mismatches  <= mismatches_next;
        run_begin   <= run_begin_next;
        run_counter <= run_counter_next;
      end
    end
  end

  `ASSERT_IMPLIES(a_final_pushes, clk, rst, accept && final_byte, push)
  `ASSERT_NEVER(a_pending_range, clk, rst, pending > ipc_pkg::PEND_W'(WinDepth))

endmodule

`default_nettype wire

>>> hw/rtl/ipc_queue.sv
`default_nettype none

`include "assert_macros.svh"

module ipc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire ipc_pkg::event_t  push_event,
  input  wire logic             pop,
  output ipc_pkg::event_t       head,
  output logic                  empty,
  output logic                  full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  ipc_pkg::event_t       slots [DEPTH];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;

  assign empty = (count == '0);
  assign full  = (count == CntW'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, clk, rst, push && full && !pop)
  `ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty)

endmodule

`default_nettype wire

>>> hw/rtl/ipc_back.sv
`default_nettype none

`include "assert_macros.svh"

module ipc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ipc_pkg::event_t  head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  report_kind,
  output logic [31:0]           run_start,
  output logic [31:0]           run_length,
  output logic [31:0]           total_runs,
  output logic                  last_of_run
);

  ipc_pkg::event_t cur;
  logic            cur_valid;
  logic            run_shown;

  logic show_run;
  logic take;
  logic done;

  assign show_run = cur.run_valid && !run_shown;
  assign take     = cur_valid && out_ready;
  // Event is finished once its last request is taken.
  assign done     = take && (!show_run || !cur.summary_valid);
  assign pop      = !empty && (!cur_valid || done);

  assign out_valid   = cur_valid;
  assign report_kind = show_run ? ipc_pkg::KIND_RUN : ipc_pkg::KIND_SUMMARY;
  assign run_start   = show_run ? cur.run_start : '0;
  assign run_length  = show_run ? cur.run_length : '0;
  assign total_runs  = cur.total_runs;
  assign last_of_run = show_run ? !cur.summary_valid : 1'b1;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      run_shown <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      run_shown <= 1'b0;
    end else if (done) begin
      cur_valid <= 1'b0;
    end else if (take && show_run) begin
      run_shown <= 1'b1;
    end
  end

  `ASSERT_IMPLIES(a_event_nonempty, clk, rst, cur_valid, cur.run_valid || cur.summary_valid)
  `ASSERT_IMPLIES(a_shown_has_summary, clk, rst, cur_valid && run_shown, cur.summary_valid)

endmodule

`default_nettype wire

>>> hw/rtl/increment_pattern_checker_top.sv
// Incrementing-pattern checker: takes one stream byte per cycle on the
// in_valid/in_ready channel and checks that it holds consecutive 2- or 4-byte
// words (little or big endian) that each rise by one, wrapping from all ones
// to zero. Every byte is classified in the cycle it is accepted; a closed
// error run (start offset, length) and the end-of-stream summary (run count)
// are queued as events in a four-entry queue and sent one request per cycle
// if out_ready is high. A byte that ends the stream while a run is open gives
// two requests, the run first; all other bytes give zero or one. Input stalls
// only when the queue is full. Writing either configuration register restarts
// the stream; write only between streams, with all requests delivered.
`default_nettype none

module increment_pattern_checker_top #(
  parameter int OFFSET_WIDTH   = 32,
  parameter int MAX_WORD_BYTES = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ipc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic                             cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       data_byte,
  input  wire logic                             final_byte,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  report_kind,
  output logic [31:0]                           run_start,
  output logic [31:0]                           run_length,
  output logic [31:0]                           total_runs,
  output logic                                  last_of_run
);

  logic            push;
  ipc_pkg::event_t push_event;
  logic            pop;
  ipc_pkg::event_t head;
  logic            empty;
  logic            full;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;

  ipc_front #(
    .OFFSET_WIDTH   (OFFSET_WIDTH),
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .push       (push),
    .push_event (push_event)
  );

  ipc_queue #(
    .DEPTH (ipc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .pop        (pop),
    .head       (head),
    .empty      (empty),
    .full       (full)
  );

  ipc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .report_kind (report_kind),
    .run_start   (run_start),
    .run_length  (run_length),
    .total_runs  (total_runs),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire
